>>> src/mpws_pkg.sv
// mpws_pkg: shared constants, register indexes and types for the masked
// pattern window search block. Used by mpws_cfg, mpws_match and the top level.
// No dependencies.
`default_nettype none

package mpws_pkg;

    localparam int PATTERN_MAX_BYTES = 8;
    localparam int POSITION_BITS     = 16;

    localparam int BYTE_BITS   = 8;
    localparam int REG_BYTES   = 8;
    localparam int REG_BITS    = REG_BYTES * BYTE_BITS;
    localparam int LEN_BITS    = 4;
    localparam int OFFSET_BITS = 16;
    localparam int RANGE_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    // bytes actually compared: bounded by the window and by the pattern register
    localparam int CMP_BYTES = (PATTERN_MAX_BYTES < REG_BYTES) ? PATTERN_MAX_BYTES : REG_BYTES;
    localparam int WIN_IDX_BITS = (PATTERN_MAX_BYTES > 1) ? $clog2(PATTERN_MAX_BYTES) : 1;
    // start/end position arithmetic needs room for offset + range and the carry
    localparam int SPAN_BITS = ((POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS) + 2;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN = 3'd0,
        REG_MASK    = 3'd1,
        REG_LENGTH  = 3'd2,
        REG_OFFSET  = 3'd3,
        REG_RANGE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [REG_BITS-1:0]    pattern;
        logic [REG_BITS-1:0]    mask;
        logic [LEN_BITS-1:0]    length;
        logic [OFFSET_BITS-1:0] offset;
        logic [RANGE_BITS-1:0]  range;
    } t_cfg;

    typedef logic [PATTERN_MAX_BYTES-1:0][BYTE_BITS-1:0] t_window;

endpackage

`default_nettype wire

>>> src/mpws_cfg.sv
// mpws_cfg: configuration register file for the pattern search.
// Depends on mpws_pkg for register indexes and the t_cfg struct.
`default_nettype none

module mpws_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mpws_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [mpws_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output mpws_pkg::t_cfg                            o_cfg
);

    mpws_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.mask    <= '1;
            r_cfg.length  <= '0;
            r_cfg.offset  <= '0;
            r_cfg.range   <= '0;
        end else if (i_cfg_valid) begin
            unique case (mpws_pkg::t_reg_idx'(i_cfg_index))
                mpws_pkg::REG_PATTERN: r_cfg.pattern <= i_cfg_data[mpws_pkg::REG_BITS-1:0];
                mpws_pkg::REG_MASK:    r_cfg.mask    <= i_cfg_data[mpws_pkg::REG_BITS-1:0];
                mpws_pkg::REG_LENGTH:  r_cfg.length  <= i_cfg_data[mpws_pkg::LEN_BITS-1:0];
                mpws_pkg::REG_OFFSET:  r_cfg.offset  <= i_cfg_data[mpws_pkg::OFFSET_BITS-1:0];
                mpws_pkg::REG_RANGE:   r_cfg.range   <= i_cfg_data[mpws_pkg::RANGE_BITS-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/mpws_match.sv
// mpws_match: combinational masked compare of the byte window against the
// pattern, plus the allowed start position check. Depends on mpws_pkg.
`default_nettype none

module mpws_match (
    input  wire mpws_pkg::t_cfg                       i_cfg,
    input  wire mpws_pkg::t_window                    i_window,
    input  wire logic [mpws_pkg::POSITION_BITS-1:0]   i_pos,
    output logic                                      o_hit
);

    logic [mpws_pkg::SPAN_BITS-1:0]  w_end;
    logic [mpws_pkg::SPAN_BITS-1:0]  w_len;
    logic [mpws_pkg::SPAN_BITS-1:0]  w_start;
    logic [mpws_pkg::SPAN_BITS-1:0]  w_lo;
    logic [mpws_pkg::SPAN_BITS-1:0]  w_hi;
    logic                            w_len_ok;
    logic                            w_pos_ok;
    logic [mpws_pkg::CMP_BYTES-1:0]  w_byte_ok;

    always_comb begin
        w_end   = mpws_pkg::SPAN_BITS'(i_pos) + mpws_pkg::SPAN_BITS'(1);
        w_len   = mpws_pkg::SPAN_BITS'(i_cfg.length);
        w_start = w_end - w_len;
        w_lo    = mpws_pkg::SPAN_BITS'(i_cfg.offset);
        w_hi    = w_lo + mpws_pkg::SPAN_BITS'(i_cfg.range);

        w_len_ok = (i_cfg.length != '0)
                && (i_cfg.length <= mpws_pkg::LEN_BITS'(mpws_pkg::CMP_BYTES));
        // window must be full enough, then start within [offset, offset+range), or at/after offset when range is 0
        w_pos_ok = (w_end >= w_len) && (w_start >= w_lo)
                && ((i_cfg.range == '0) || (w_start < w_hi));
    end

    // pattern byte i lines up with the byte received length-1-i items ago
    always_comb begin
        for (int i = 0; i < mpws_pkg::CMP_BYTES; i++) begin
            logic [mpws_pkg::WIN_IDX_BITS-1:0] sel;
            logic [mpws_pkg::BYTE_BITS-1:0]    m;
            logic [mpws_pkg::BYTE_BITS-1:0]    p;
            sel = mpws_pkg::WIN_IDX_BITS'(i_cfg.length - mpws_pkg::LEN_BITS'(1)
                                          - mpws_pkg::LEN_BITS'(i));
            m   = i_cfg.mask[i*mpws_pkg::BYTE_BITS +: mpws_pkg::BYTE_BITS];
            p   = i_cfg.pattern[i*mpws_pkg::BYTE_BITS +: mpws_pkg::BYTE_BITS];
            w_byte_ok[i] = (mpws_pkg::LEN_BITS'(i) >= i_cfg.length)
                        || ((i_window[sel] & m) == (p & m));
        end
    end

    assign o_hit = w_len_ok && w_pos_ok && (&w_byte_ok);

endmodule

`default_nettype wire

>>> src/masked_pattern_window_search.sv
// masked_pattern_window_search: top level. Input register, window and
// position state, result register. Depends on mpws_pkg, mpws_cfg, mpws_match.
//
// Usage:
//   s_axis carries packet bytes, one item per byte (tdata[7:0]), tlast on the
//   final byte of the packet. m_axis carries one item per packet: tdata[0] is
//   found, set when the masked pattern matched at an allowed start position.
//   The config channel writes one register per item: 0 pattern, 1 mask,
//   2 length, 3 start offset, 4 search range; other indexes are dropped.
//   Write config only while no packet is in flight.
// Timing:
//   One byte is accepted every cycle unless a last byte waits in the input
//   register behind a held result. Each byte is held in the input register;
//   the window shift, masked compare and position check then load the state
//   and result registers, so m_axis_tvalid is set as the last byte leaves it.
// Reset: synchronous, active low; clears the window, position, seen flag
//   and both valids, and loads the register defaults (mask all ones).
// Stall:
//   A held result blocks only the next last byte; ordinary bytes keep
//   flowing into the window while m_axis_tready is low.
`default_nettype none

module masked_pattern_window_search (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // config write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mpws_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [mpws_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // packet bytes in
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [7:0]                           s_axis_tdata,   // [7:0] packet_byte
    input  wire logic                                 s_axis_tlast,   // last_byte
    // result out
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [7:0]                                m_axis_tdata    // [0] found, [7:1] zero
);

    mpws_pkg::t_cfg                     w_cfg;

    logic                               r_s1_valid;
    logic [mpws_pkg::BYTE_BITS-1:0]     r_s1_byte;
    logic                               r_s1_last;

    mpws_pkg::t_window                  r_window;
    mpws_pkg::t_window                  n_window;
    logic [mpws_pkg::POSITION_BITS-1:0] r_pos;
    logic [mpws_pkg::POSITION_BITS-1:0] n_pos;
    logic                               r_seen;
    logic                               n_seen;

    logic                               r_out_valid;
    logic                               r_found;

    logic                               w_hit;
    logic                               w_s1_fire;
    logic                               w_in_fire;

    mpws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // a non-last item never needs the result slot
    assign w_s1_fire = r_s1_valid && (!r_s1_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_fire;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_window[0] = r_s1_byte;
        for (int k = 1; k < mpws_pkg::PATTERN_MAX_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_pos = (r_pos == mpws_pkg::POS_MAX) ? r_pos
                                            : r_pos + mpws_pkg::POSITION_BITS'(1);
    end

    mpws_match u_match (
        .i_cfg    (w_cfg),
        .i_window (n_window),
        .i_pos    (r_pos),
        .o_hit    (w_hit)
    );

    assign n_seen = r_seen || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_byte <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_pos    <= '0;
            r_seen   <= 1'b0;
        end else if (w_s1_fire) begin
            if (r_s1_last) begin
                r_window <= '0;
                r_pos    <= '0;
                r_seen   <= 1'b0;
            end else begin
                r_window <= n_window;
                r_pos    <= n_pos;
                r_seen   <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_last) begin
            r_found <= n_seen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_found};

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_s1_fire && r_s1_last))
        else $error("result raised without a last item");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_s1_last) |=> (r_pos == '0 && !r_seen && r_window == '0))
        else $error("state not cleared after last item");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && !r_s1_last && r_pos != mpws_pkg::POS_MAX)
        |=> (r_pos == $past(r_pos) + mpws_pkg::POSITION_BITS'(1)))
        else $error("position did not advance by one");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(w_s1_fire && r_s1_last))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> tb/sv/mpws_checker.sv
// mpws_checker: watches the register, packet byte and result channels of
// masked_pattern_window_search, predicts the found flag of each packet and compares.
// Depends on mpws_pkg.

module mpws_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [mpws_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [mpws_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [7:0]                         i_in_data,    // [7:0] packet byte
    input  wire logic                               i_in_last,    // last byte of packet
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [7:0]                         i_out_data,   // [0] found, [7:1] zero
    output int                                      o_errors,
    output int                                      o_outstanding,
    output int                                      o_packets_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    mpws_pkg::t_cfg                     regs;
    mpws_pkg::t_window                  hist;
    logic [mpws_pkg::POSITION_BITS-1:0] next_pos;
    logic                               hit_seen;
    logic                               found_due[$];
    logic                               want;
    int                                 errors = 0;
    int                                 checked = 0;

    // true when the window, newest byte already in, ends a masked match at position idx
    function automatic logic masked_hit(input mpws_pkg::t_window w,
                                        input logic [mpws_pkg::POSITION_BITS-1:0] idx,
                                        input mpws_pkg::t_cfg c);
        int len;
        int start;
        int i;
        logic [mpws_pkg::BYTE_BITS-1:0] m;
        logic [mpws_pkg::BYTE_BITS-1:0] p;
        len = int'(c.length);
        if (len == 0 || len > mpws_pkg::PATTERN_MAX_BYTES || len > mpws_pkg::REG_BYTES)
            return 1'b0;
        if (int'(idx) + 1 < len) return 1'b0;
        start = int'(idx) + 1 - len;
        if (start < int'(c.offset)) return 1'b0;
        // offset + range is wider than 16 bits here on purpose
        if (c.range != '0 && start >= int'(c.offset) + int'(c.range)) return 1'b0;
        for (i = 0; i < len; i++) begin
            m = c.mask[mpws_pkg::BYTE_BITS*i +: mpws_pkg::BYTE_BITS];
            p = c.pattern[mpws_pkg::BYTE_BITS*i +: mpws_pkg::BYTE_BITS];
            if ((w[len-1-i] & m) != (p & m)) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.pattern = '0;
            regs.mask    = '1;
            regs.length  = '0;
            regs.offset  = '0;
            regs.range   = '0;
            hist         = '0;
            next_pos     = '0;
            hit_seen     = 1'b0;
            found_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (mpws_pkg::t_reg_idx'(i_cfg_index))
                    mpws_pkg::REG_PATTERN: regs.pattern = i_cfg_data;
                    mpws_pkg::REG_MASK:    regs.mask    = i_cfg_data;
                    mpws_pkg::REG_LENGTH:  regs.length  = i_cfg_data[mpws_pkg::LEN_BITS-1:0];
                    mpws_pkg::REG_OFFSET:  regs.offset  = i_cfg_data[mpws_pkg::OFFSET_BITS-1:0];
                    mpws_pkg::REG_RANGE:   regs.range   = i_cfg_data[mpws_pkg::RANGE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                hist = {hist[mpws_pkg::PATTERN_MAX_BYTES-2:0], i_in_data};
                if (masked_hit(hist, next_pos, regs)) hit_seen = 1'b1;
                if (next_pos != mpws_pkg::POS_MAX) next_pos = next_pos + 1'b1;
                if (i_in_last) begin
                    found_due = {found_due, hit_seen};
                    hist     = '0;
                    next_pos = '0;
                    hit_seen = 1'b0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (found_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual found %0b",
                             $time, i_out_data[0]);
                end else begin
                    want = found_due.pop_front();
                    checked++;
                    if (i_out_data[0] !== want) begin
                        errors++;
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want, i_out_data[0]);
                    end
                    if (i_out_data[7:1] !== 7'd0) begin
                        errors++;
                        $display("%0t: padding mismatch, expected 00, actual %h",
                                 $time, i_out_data[7:1]);
                    end
                end
            end
        end
        o_errors          <= errors;
        o_outstanding     <= found_due.size();
        o_packets_checked <= checked;
    end

endmodule

>>> tb/sv/testbench.sv
// testbench: drives register writes and packets into masked_pattern_window_search
// under several idle/stall mixes; mpws_checker predicts and compares the results.
// Depends on mpws_pkg, mpws_checker and the block.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_BYTES   = 90;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [mpws_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [mpws_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic [7:0]                         s_axis_tdata = '0;
    logic                               s_axis_tlast = 1'b0;
    logic                               m_axis_tready = 1'b0;
    logic                               o_cfg_ready;
    logic                               s_axis_tready;
    logic                               m_axis_tvalid;
    logic [7:0]                         m_axis_tdata;

    int errors;
    int outstanding;
    int results_checked;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int reg_writes = 0;
    int idle_plan[4] = '{0, 52, 0, 12};
    int stall_plan[4] = '{0, 0, 52, 12};
    int phase_start;

    logic [7:0]                         byte_q[$];
    logic [mpws_pkg::CFG_IDX_BITS-1:0]  reg_idx_q[$];
    logic [mpws_pkg::CFG_DATA_BITS-1:0] reg_val_q[$];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    masked_pattern_window_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mpws_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (s_axis_tvalid),
        .i_in_ready        (s_axis_tready),
        .i_in_data         (s_axis_tdata),
        .i_in_last         (s_axis_tlast),
        .i_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .i_out_data        (m_axis_tdata),
        .o_errors          (errors),
        .o_outstanding     (outstanding),
        .o_packets_checked (results_checked)
    );

    function automatic void fill_bytes(input int n, input logic [7:0] value);
        byte_q.delete();
        repeat (n) byte_q = {byte_q, value};
    endfunction

    function automatic void add_write(input logic [mpws_pkg::CFG_IDX_BITS-1:0] idx,
                                      input logic [mpws_pkg::CFG_DATA_BITS-1:0] val);
        reg_idx_q = {reg_idx_q, idx};
        reg_val_q = {reg_val_q, val};
    endfunction

    // one packet from byte_q, tlast on its final byte, random sender gaps
    task automatic send_packet();
        int k;
        for (k = 0; k < byte_q.size(); k++) begin
            while ($urandom_range(99) < idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= byte_q[k];
            s_axis_tlast  <= (k == byte_q.size() - 1);
            do @(posedge i_clk); while (!s_axis_tready);
        end
        bytes_sent += byte_q.size();
        packets_sent++;
    endtask

    // wait until every packet has its result and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs();
        int k;
        drain();
        for (k = 0; k < reg_idx_q.size(); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx_q[k];
            i_cfg_data  <= reg_val_q[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        reg_writes += reg_idx_q.size();
        reg_idx_q.delete();
        reg_val_q.delete();
    endtask

    // writes all five registers, sometimes plus one unused index; unused upper data bits sometimes carry junk
    task automatic config_all(input logic [63:0] pat, input logic [63:0] msk,
                              input logic [3:0] len, input logic [15:0] off,
                              input logic [15:0] rng);
        logic [mpws_pkg::CFG_DATA_BITS-1:0] hi;
        hi = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
        add_write(mpws_pkg::REG_PATTERN, pat);
        add_write(mpws_pkg::REG_MASK, msk);
        add_write(mpws_pkg::REG_LENGTH, {hi[mpws_pkg::CFG_DATA_BITS-1:mpws_pkg::LEN_BITS], len});
        add_write(mpws_pkg::REG_OFFSET,
                  {hi[mpws_pkg::CFG_DATA_BITS-1:mpws_pkg::OFFSET_BITS], off});
        add_write(mpws_pkg::REG_RANGE,
                  {hi[mpws_pkg::CFG_DATA_BITS-1:mpws_pkg::RANGE_BITS], rng});
        if ($urandom_range(4) == 0) begin
            add_write(mpws_pkg::CFG_IDX_BITS'($urandom_range((1 << mpws_pkg::CFG_IDX_BITS) - 1,
                                                   int'(mpws_pkg::REG_RANGE) + 1)),
                      {$urandom, $urandom});
        end
        load_regs();
    endtask

    // random settings, then a few packets, most with the pattern planted in or near the window
    task automatic random_round();
        logic [63:0] pat;
        logic [63:0] msk;
        logic [7:0]  m;
        int r;
        int i;
        int len;
        int off;
        int rng;
        int plen;
        int s;
        int span;
        r = $urandom_range(9);
        len = (r == 0) ? 0 : (r == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1);
        pat = {$urandom, $urandom};
        for (i = 0; i < 8; i++) begin
            r = $urandom_range(19);
            msk[8*i +: 8] = (r < 10) ? 8'hFF : (r < 17) ? 8'($urandom) : 8'h00;
        end
        off = ($urandom_range(6) == 0) ? $urandom_range(65535) : $urandom_range(5);
        r = $urandom_range(19);
        rng = (r < 8) ? 0 : (r < 11) ? 1 : (r < 18) ? $urandom_range(6, 2)
                                                    : $urandom_range(65535);
        config_all(pat, msk, len[3:0], off[15:0], rng[15:0]);
        repeat ($urandom_range(4, 1)) begin
            plen = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : $urandom_range(16, 1);
            byte_q.delete();
            repeat (plen) byte_q = {byte_q, 8'($urandom)};
            if ($urandom_range(9) < 7 && len >= 1 && len <= 8) begin
                if ($urandom_range(3) == 0) begin
                    // just outside the allowed start window
                    s = $urandom_range(1) ? off - 1 : off + ((rng == 0) ? plen : rng);
                end else begin
                    span = (rng == 0 || rng > 9) ? 8 : rng - 1;
                    s = off + $urandom_range(span);
                end
                if (s >= 0 && s + len <= plen) begin
                    for (i = 0; i < len; i++) begin
                        m = msk[8*i +: 8];
                        byte_q[s+i] = (pat[8*i +: 8] & m) | (8'($urandom) & ~m);
                    end
                    if ($urandom_range(4) == 0) begin
                        i = $urandom_range(len - 1);
                        byte_q[s+i] = byte_q[s+i] ^ (8'h1 << $urandom_range(7));
                    end
                end
            end
            send_packet();
        end
    endtask

    initial begin
        int ph;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: empty pattern, single-byte packet
        fill_bytes(1, 8'hFF);
        send_packet();
        // full eight-byte pattern of ones
        config_all('1, '1, 4'd8, 16'd0, 16'd0);
        fill_bytes(8, 8'hFF);
        send_packet();
        // exact-offset check on a single-byte packet
        config_all(64'hFF, '1, 4'd1, 16'd0, 16'd1);
        fill_bytes(1, 8'hFF);
        send_packet();
        // zero mask: packet shorter than the pattern, then just long enough
        config_all('0, '0, 4'd3, 16'd0, 16'd0);
        fill_bytes(2, 8'hA5);
        send_packet();
        fill_bytes(3, 8'hA5);
        send_packet();
        // writes to unused indexes must not touch any register
        for (k = int'(mpws_pkg::REG_RANGE) + 1; k < (1 << mpws_pkg::CFG_IDX_BITS); k++) begin
            add_write(mpws_pkg::CFG_IDX_BITS'(k), 64'hFFFF_FFFF_FFFF_FFF0);
        end
        load_regs();
        fill_bytes(3, 8'hA5);
        send_packet();
        // length beyond the eight bytes held
        config_all('1, '0, 4'd9, 16'd0, 16'd0);
        fill_bytes(9, 8'h00);
        send_packet();

        for (ph = 0; ph < 4; ph++) begin
            drain();
            idle_pct    = idle_plan[ph];
            stall_pct   = stall_plan[ph];
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_round();
        end

        drain();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        $display("drove %0d packets, %0d bytes and %0d register writes; %0d results checked",
                 packets_sent, bytes_sent, reg_writes, results_checked);
        $display("covered idle/stall mixes, masks, window edges, bad lengths, short packets");
        if (errors == 0) begin
            $display("masked_pattern_window_search test passed");
        end else begin
            $display("masked_pattern_window_search test failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout: %0d results still outstanding", outstanding);
        $display("masked_pattern_window_search test failed");
        $finish;
    end

endmodule
